// ===== hw/rtl/iqsof_pkg.sv =====
// Shared types, widths, constants and helpers of the IQ stereo output formatter.
package iqsof_pkg;

   // Field and register widths.
   localparam int SAMPLE_W = 18;
   localparam int GAIN_W   = 24;
   localparam int OUT_W    = 16;

   // CORDIC sizing. The angle table has 24 entries, so the step count is limited to it.
   localparam int CORDIC_STEPS = 16;
   localparam int TABLE_LEN    = 24;
   localparam int NSTEPS       = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
   localparam int ATAN_W       = 24;
   localparam int PRE_SHIFT    = 8;
   localparam int XY_W         = 29;
   localparam int Z_W          = 28;

   // Output arithmetic.
   localparam int GAIN_SHIFT = 27;
   localparam int ENV_SHIFT  = 39;
   localparam int PH_SHIFT   = 24;
   localparam int INV_W      = 24;
   localparam int PH_SCALE_W = 14;
   localparam int ENV_PROD_W = XY_W - 1 + INV_W;
   localparam int PH_PROD_W  = Z_W + PH_SCALE_W;
   localparam int SC_PROD_W  = SAMPLE_W + GAIN_W + 1;
   localparam int SAT_IN_W   = 48;

   localparam logic signed [Z_W-1:0]        ANG_PI      = Z_W'(52707179);
   localparam logic [INV_W-1:0]             INV_GAIN    = INV_W'(10188014);
   localparam logic signed [PH_SCALE_W-1:0] PH_SCALE    = PH_SCALE_W'(5000);
   localparam logic signed [SAT_IN_W-1:0]   SAT_MAX     = SAT_IN_W'(32767);
   localparam logic signed [SAT_IN_W-1:0]   SAT_MIN     = -SAT_IN_W'(32768);
   localparam logic signed [OUT_W-1:0]      PHASE_LIMIT = OUT_W'(15707);

   // atan(2^-k) in radians times 2^24, rounded to nearest.
   localparam logic [ATAN_W-1:0] ATAN_TAB [TABLE_LEN] = '{
      24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331,
      24'd1047214,  24'd524117,  24'd262123,  24'd131069,
      24'd65536,    24'd32768,   24'd16384,   24'd8192,
      24'd4096,     24'd2048,    24'd1024,    24'd512,
      24'd256,      24'd128,     24'd64,      24'd32,
      24'd16,       24'd8,       24'd4,       24'd2
   };

   typedef enum logic [1:0] {
      FMT_REAL_BOTH = 2'd0,
      FMT_I_Q       = 2'd1,
      FMT_Q_I       = 2'd2,
      FMT_ENV_PHASE = 2'd3
   } fmt_type;

   typedef enum logic [0:0] {
      CSR_OUTPUT_FORMAT = 1'b0,
      CSR_NORM_GAIN     = 1'b1
   } csr_index_type;

   // One word in flight through the rotation pipeline.
   typedef struct packed {
      logic                       valid;
      logic                       zero;
      logic signed [SAMPLE_W-1:0] i;
      logic signed [SAMPLE_W-1:0] q;
      logic signed [XY_W-1:0]     x;
      logic signed [XY_W-1:0]     y;
      logic signed [Z_W-1:0]      z;
   } cordic_word_type;

   // One word after the product stage.
   typedef struct packed {
      logic                        valid;
      logic                        zero;
      logic [ENV_PROD_W-1:0]       env_prod;
      logic signed [PH_PROD_W-1:0] ph_prod;
      logic signed [SC_PROD_W-1:0] si_prod;
      logic signed [SC_PROD_W-1:0] sq_prod;
   } mult_word_type;

   function automatic logic signed [OUT_W-1:0] sat16(input logic signed [SAT_IN_W-1:0] v);
      logic signed [OUT_W-1:0] r;
      if (v > SAT_MAX) begin
         r = SAT_MAX[OUT_W-1:0];
      end else if (v < SAT_MIN) begin
         r = SAT_MIN[OUT_W-1:0];
      end else begin
         r = v[OUT_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/iqsof_req_if.sv =====
// Input channel of the formatter: valid, ready and one complex sample.
interface iqsof_req_if;
   import iqsof_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] in_i;
   logic signed [SAMPLE_W-1:0] in_q;

   modport source (output valid, output in_i, output in_q, input ready);
   modport sink   (input valid, input in_i, input in_q, output ready);
endinterface

// ===== hw/rtl/iqsof_rsp_if.sv =====
// Result channel of the formatter: valid, ready and one left/right sample pair.
interface iqsof_rsp_if;
   import iqsof_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] left_sample;
   logic signed [OUT_W-1:0] right_sample;

   modport source (output valid, output left_sample, output right_sample, input ready);
   modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

// ===== hw/rtl/iq_stereo_output_formatter_unit.sv =====
// Top level of the IQ stereo output formatter: configuration registers, pipeline control and stages.
//
// Every word on req_chan is one complex sample (signed Q2.15 I and Q) and yields exactly one
// word on rsp_chan, a pair of 16-bit left/right samples selected by output_format: the scaled
// real part on both channels, scaled I/Q, scaled Q/I, or envelope and phase. Scaled values are
// the sample times norm_gain (unsigned Q12.12) divided by 2^27, truncated toward zero and
// saturated. Envelope and phase come from a vectoring CORDIC: envelope is magnitude*256 and
// phase is atan2(Q, I)*5000, both truncated toward zero, the phase within +-15707. The block
// accepts a new word in every cycle in which the result side is not stalled, so it sustains one
// word per cycle. The pipeline is one entry stage that folds the vector into the right half
// plane, one registered stage per CORDIC iteration, one product stage, and the output register.
// The whole pipeline holds still while a finished word waits on rsp_chan; nothing is lost or
// repeated across a stall. Configuration is written through csr_we, csr_index and csr_data and
// takes effect at once; it should only be written while no word is in flight.
module iq_stereo_output_formatter_unit (
   input  logic                          clock,
   input  logic                          reset,
   iqsof_req_if.sink                     req_chan,
   iqsof_rsp_if.source                   rsp_chan,
   input  logic                          csr_we,
   input  iqsof_pkg::csr_index_type      csr_index,
   input  logic [iqsof_pkg::GAIN_W-1:0]  csr_data
);
   import iqsof_pkg::*;

   fmt_type             fmt_ff;
   logic [GAIN_W-1:0]   gain_ff;
   logic                advance;
   logic                out_valid;
   cordic_word_type     prep_word;
   cordic_word_type     cordic_word;

   // Configuration registers. Only the low bits of the data word are kept for the format.
   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff  <= FMT_REAL_BOTH;
         gain_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_OUTPUT_FORMAT: fmt_ff  <= fmt_type'(csr_data[1:0]);
            CSR_NORM_GAIN:     gain_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // All stages move together whenever the output register is empty or being emptied.
   assign advance        = !out_valid || rsp_chan.ready;
   assign req_chan.ready = advance;
   assign rsp_chan.valid = out_valid;

   iqsof_prep u_prep (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req_chan.valid),
      .in_i     (req_chan.in_i),
      .in_q     (req_chan.in_q),
      .word_out (prep_word)
   );

   iqsof_cordic u_cordic (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .word_in  (prep_word),
      .word_out (cordic_word)
   );

   iqsof_post u_post (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .word_in   (cordic_word),
      .gain      (gain_ff),
      .fmt       (fmt_ff),
      .out_valid (out_valid),
      .out_left  (rsp_chan.left_sample),
      .out_right (rsp_chan.right_sample)
   );

endmodule

// ===== hw/rtl/iqsof_prep.sv =====
// Entry stage: folds the vector into the right half plane and sets up the CORDIC start values.
module iqsof_prep (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic                                 in_valid,
   input  logic signed [iqsof_pkg::SAMPLE_W-1:0] in_i,
   input  logic signed [iqsof_pkg::SAMPLE_W-1:0] in_q,
   output iqsof_pkg::cordic_word_type           word_out
);
   import iqsof_pkg::*;

   localparam int EXT_W = XY_W - SAMPLE_W - 1 - PRE_SHIFT;

   logic                     neg;
   logic signed [SAMPLE_W:0] ai;
   logic signed [SAMPLE_W:0] aq;
   cordic_word_type          word_in;
   cordic_word_type          word_ff;

   always_comb begin
      neg = in_i[SAMPLE_W-1];
      ai  = {in_i[SAMPLE_W-1], in_i};
      aq  = {in_q[SAMPLE_W-1], in_q};
      if (neg) begin
         ai = -ai;
         aq = -aq;
      end
      word_in.valid = in_valid;
      word_in.zero  = (in_i == '0) && (in_q == '0);
      word_in.i     = in_i;
      word_in.q     = in_q;
      word_in.x     = {{EXT_W{ai[SAMPLE_W]}}, ai, {PRE_SHIFT{1'b0}}};
      word_in.y     = {{EXT_W{aq[SAMPLE_W]}}, aq, {PRE_SHIFT{1'b0}}};
      if (!neg) begin
         word_in.z = '0;
      end else if (!in_q[SAMPLE_W-1]) begin
         word_in.z = ANG_PI;
      end else begin
         word_in.z = -ANG_PI;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.valid <= 1'b0;
      end else if (advance) begin
         word_ff <= word_in;
      end
   end

   assign word_out = word_ff;

endmodule

// ===== hw/rtl/iqsof_cordic.sv =====
// Vectoring CORDIC: one registered stage per iteration.
module iqsof_cordic (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  iqsof_pkg::cordic_word_type word_in,
   output iqsof_pkg::cordic_word_type word_out
);
   import iqsof_pkg::*;

   cordic_word_type tap     [NSTEPS+1];
   cordic_word_type step_in [NSTEPS];
   cordic_word_type step_ff [NSTEPS];

   assign tap[0] = word_in;

   for (genvar k = 0; k < NSTEPS; k++) begin : g_step
      logic                   rot_cw;
      logic signed [XY_W-1:0] dx;
      logic signed [XY_W-1:0] dy;
      logic signed [Z_W-1:0]  da;

      always_comb begin
         rot_cw     = !tap[k].y[XY_W-1] && (tap[k].y != '0);
         dx         = tap[k].y >>> k;
         dy         = tap[k].x >>> k;
         da         = {{(Z_W-ATAN_W){1'b0}}, ATAN_TAB[k]};
         step_in[k] = tap[k];
         if (rot_cw) begin
            step_in[k].x = tap[k].x + dx;
            step_in[k].y = tap[k].y - dy;
            step_in[k].z = tap[k].z + da;
         end else begin
            step_in[k].x = tap[k].x - dx;
            step_in[k].y = tap[k].y + dy;
            step_in[k].z = tap[k].z - da;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            step_ff[k].valid <= 1'b0;
         end else if (advance) begin
            step_ff[k] <= step_in[k];
         end
      end

      assign tap[k+1] = step_ff[k];
   end

   assign word_out = tap[NSTEPS];

endmodule

// ===== hw/rtl/iqsof_post.sv =====
// Product stage and output stage: scaling, envelope, phase, format select and output register.
module iqsof_post (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               advance,
   input  iqsof_pkg::cordic_word_type         word_in,
   input  logic [iqsof_pkg::GAIN_W-1:0]        gain,
   input  iqsof_pkg::fmt_type                 fmt,
   output logic                               out_valid,
   output logic signed [iqsof_pkg::OUT_W-1:0]  out_left,
   output logic signed [iqsof_pkg::OUT_W-1:0]  out_right
);
   import iqsof_pkg::*;

   localparam int ENV_Q_W = ENV_PROD_W - ENV_SHIFT;

   logic signed [Z_W-1:0]       zc;
   logic [XY_W-2:0]             xc;
   logic signed [GAIN_W:0]      gain_s;
   mult_word_type               mult_in;
   mult_word_type               mult_ff;

   logic signed [SC_PROD_W-1:0] si_adj;
   logic signed [SC_PROD_W-1:0] sq_adj;
   logic signed [PH_PROD_W-1:0] ph_adj;
   logic signed [SC_PROD_W-1:0] si_q;
   logic signed [SC_PROD_W-1:0] sq_q;
   logic signed [PH_PROD_W-1:0] ph_q;
   logic signed [OUT_W-1:0]     si_val;
   logic signed [OUT_W-1:0]     sq_val;
   logic signed [OUT_W-1:0]     env_val;
   logic signed [OUT_W-1:0]     ph_val;
   logic signed [OUT_W-1:0]     left_in;
   logic signed [OUT_W-1:0]     right_in;
   logic                        valid_ff;
   logic signed [OUT_W-1:0]     left_ff;
   logic signed [OUT_W-1:0]     right_ff;

   // Product stage.
   always_comb begin
      if (word_in.z > ANG_PI) begin
         zc = ANG_PI;
      end else if (word_in.z < -ANG_PI) begin
         zc = -ANG_PI;
      end else begin
         zc = word_in.z;
      end
      xc     = word_in.x[XY_W-1] ? '0 : word_in.x[XY_W-2:0];
      gain_s = $signed({1'b0, gain});

      mult_in.valid    = word_in.valid;
      mult_in.zero     = word_in.zero;
      mult_in.env_prod = xc * INV_GAIN;
      mult_in.ph_prod  = zc * PH_SCALE;
      mult_in.si_prod  = word_in.i * gain_s;
      mult_in.sq_prod  = word_in.q * gain_s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mult_ff.valid <= 1'b0;
      end else if (advance) begin
         mult_ff <= mult_in;
      end
   end

   // Output stage: divisions by powers of two truncate toward zero.
   always_comb begin
      si_adj = mult_ff.si_prod;
      sq_adj = mult_ff.sq_prod;
      ph_adj = mult_ff.ph_prod;
      if (mult_ff.si_prod[SC_PROD_W-1]) begin
         si_adj = mult_ff.si_prod + {{(SC_PROD_W-GAIN_SHIFT){1'b0}}, {GAIN_SHIFT{1'b1}}};
      end
      if (mult_ff.sq_prod[SC_PROD_W-1]) begin
         sq_adj = mult_ff.sq_prod + {{(SC_PROD_W-GAIN_SHIFT){1'b0}}, {GAIN_SHIFT{1'b1}}};
      end
      if (mult_ff.ph_prod[PH_PROD_W-1]) begin
         ph_adj = mult_ff.ph_prod + {{(PH_PROD_W-PH_SHIFT){1'b0}}, {PH_SHIFT{1'b1}}};
      end
      si_q = si_adj >>> GAIN_SHIFT;
      sq_q = sq_adj >>> GAIN_SHIFT;
      ph_q = ph_adj >>> PH_SHIFT;

      si_val  = sat16({{(SAT_IN_W-SC_PROD_W){si_q[SC_PROD_W-1]}}, si_q});
      sq_val  = sat16({{(SAT_IN_W-SC_PROD_W){sq_q[SC_PROD_W-1]}}, sq_q});
      ph_val  = sat16({{(SAT_IN_W-PH_PROD_W){ph_q[PH_PROD_W-1]}}, ph_q});
      env_val = sat16({{(SAT_IN_W-ENV_Q_W){1'b0}},
                       mult_ff.env_prod[ENV_PROD_W-1:ENV_SHIFT]});
      if (mult_ff.zero) begin
         ph_val  = '0;
         env_val = '0;
      end

      unique case (fmt)
         FMT_REAL_BOTH: begin
            left_in  = si_val;
            right_in = si_val;
         end
         FMT_I_Q: begin
            left_in  = si_val;
            right_in = sq_val;
         end
         FMT_Q_I: begin
            left_in  = sq_val;
            right_in = si_val;
         end
         FMT_ENV_PHASE: begin
            left_in  = env_val;
            right_in = ph_val;
         end
         default: begin
            left_in  = si_val;
            right_in = si_val;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= mult_ff.valid;
         left_ff  <= left_in;
         right_ff <= right_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_left  = left_ff;
   assign out_right = right_ff;

   // The clamped angle keeps the phase within plus and minus pi times 5000.
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      mult_ff.valid |-> (ph_val <= PHASE_LIMIT) && (ph_val >= -PHASE_LIMIT))
      else $error("phase outside the range of plus and minus pi");

   // The envelope comes from a clamped, non-negative magnitude.
   a_env_sign: assert property (@(posedge clock) disable iff (reset)
      mult_ff.valid |-> !env_val[OUT_W-1])
      else $error("negative envelope");

   // A zero vector never rotates, so its magnitude product stays zero.
   a_zero_vector: assert property (@(posedge clock) disable iff (reset)
      mult_ff.valid && mult_ff.zero |-> (mult_ff.env_prod == '0))
      else $error("zero vector produced a nonzero magnitude");

endmodule
